// File: sv/stic_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stic_pkg: shared types and constants
// Table geometry, item codes and the controller, datapath and lane interface structs.
// ---------------------------------------------------------------------------
package stic_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int MATCH_W     = 20;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_PROBE  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_PROBED  = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic load_a;
    logic load_b;
    logic clear;
    logic start;
    logic run;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  search_done;
  } dp_stat_t;

  // datapath -> one search lane
  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic run;
  } lane_cmd_t;

  // search lane -> datapath
  typedef struct packed {
    logic full;
    logic done;
    logic found;
  } lane_stat_t;

endpackage

// File: sv/stic_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stic_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module stic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/stic_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stic_lane: one sorted table with its fill count and binary search
// One probe of the RAM per cycle; the next midpoint is formed from the
// compare of the data just read.
// ---------------------------------------------------------------------------
module stic_lane import stic_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  lane_cmd_t                 cmd,
  input  logic signed [VALUE_W-1:0] key,
  output lane_stat_t                stat
);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi1;      // exclusive upper bound
  logic [ADDR_W-1:0]  mid_q;    // address of the data now on rd_data
  logic               busy;
  logic               done;
  logic               found;

  logic [VALUE_W-1:0] rd_data;
  logic               full;
  logic [CNT_W-1:0]   lo_c;
  logic [CNT_W-1:0]   hi_c;
  logic               hit_now;
  logic               active;
  logic               issue;
  logic [CNT_W:0]     mid_sum;
  logic [ADDR_W-1:0]  mid_c;
  logic signed [VALUE_W-1:0] entry;

  assign full  = (count >= CNT_W'(TABLE_DEPTH));
  assign entry = $signed(rd_data);

  always_comb begin
    lo_c    = lo;
    hi_c    = hi1;
    hit_now = 1'b0;
    if (cmd.start) begin
      lo_c = '0;
      hi_c = count;
    end else if (busy) begin
      if (key < entry) begin
        hi_c = CNT_W'(mid_q);
      end else if (key > entry) begin
        lo_c = CNT_W'(mid_q) + CNT_W'(1);
      end else begin
        hit_now = 1'b1;
      end
    end
  end

  assign active  = cmd.start || (cmd.run && !done);
  assign issue   = active && !hit_now && (lo_c < hi_c);
  // floor((lo + hi) / 2) over the inclusive range [lo, hi1 - 1]
  assign mid_sum = {1'b0, lo_c} + {1'b0, hi_c} - (CNT_W + 1)'(1);
  assign mid_c   = mid_sum[ADDR_W:1];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.load && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b1;
      found <= 1'b0;
    end else if (active) begin
      busy  <= issue;
      done  <= !issue;
      found <= cmd.start ? 1'b0 : (found || hit_now);
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      lo    <= lo_c;
      hi1   <= hi_c;
      mid_q <= mid_c;
    end
  end

  stic_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.load && !full),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (key),
    .rd_en   (issue),
    .rd_addr (mid_c),
    .rd_data (rd_data)
  );

  assign stat.full  = full;
  assign stat.done  = done;
  assign stat.found = found;

endmodule

// File: sv/stic_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stic_dp: datapath
// Item register, two search lanes, match counter and result register.
// ---------------------------------------------------------------------------
module stic_dp import stic_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic [1:0]                kind_in,
  input  logic signed [VALUE_W-1:0] value_in,
  output logic [1:0]                status,
  output logic                      hit,
  output logic [MATCH_W-1:0]        match_count
);

  kind_t                     kind_q;
  logic signed [VALUE_W-1:0] key_q;
  logic [MATCH_W-1:0]        match_total;
  logic [MATCH_W-1:0]        match_total_next;
  status_t                   status_next;
  logic                      hit_next;
  lane_cmd_t                 cmd_a;
  lane_cmd_t                 cmd_b;
  lane_stat_t                stat_a;
  lane_stat_t                stat_b;
  logic                      both_found;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind_t'(kind_in);
      key_q  <= value_in;
    end
  end

  assign cmd_a = '{clear: cmd.clear, load: cmd.load_a, start: cmd.start, run: cmd.run};
  assign cmd_b = '{clear: cmd.clear, load: cmd.load_b, start: cmd.start, run: cmd.run};

  stic_lane u_lane_a (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_a),
    .key  (key_q),
    .stat (stat_a)
  );

  stic_lane u_lane_b (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_b),
    .key  (key_q),
    .stat (stat_b)
  );

  assign both_found = stat_a.found && stat_b.found;

  always_comb begin
    match_total_next = match_total;
    status_next      = ST_LOADED;
    hit_next         = 1'b0;
    unique case (kind_q)
      KIND_LOAD_A: status_next = stat_a.full ? ST_DROPPED : ST_LOADED;
      KIND_LOAD_B: status_next = stat_b.full ? ST_DROPPED : ST_LOADED;
      KIND_PROBE: begin
        status_next = ST_PROBED;
        hit_next    = both_found;
        if (both_found && (match_total != '1)) begin
          match_total_next = match_total + MATCH_W'(1);
        end
      end
      KIND_CLEAR: begin
        status_next      = ST_CLEARED;
        match_total_next = '0;
      end
      default: status_next = ST_LOADED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_total <= '0;
    end else if (cmd.emit) begin
      match_total <= match_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= status_next;
      hit         <= hit_next;
      match_count <= match_total_next;
    end
  end

  assign stat.kind        = kind_q;
  assign stat.search_done = stat_a.done && stat_b.done;

endmodule

// File: sv/stic_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stic_ctrl: controller
// Sequences one item at a time and owns both handshakes.
// ---------------------------------------------------------------------------
module stic_ctrl import stic_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.kind == KIND_PROBE) begin
          cmd.start  = 1'b1;
          state_next = S_SEARCH;
        end else if (out_free) begin
          cmd.load_a = (stat.kind == KIND_LOAD_A);
          cmd.load_b = (stat.kind == KIND_LOAD_B);
          cmd.clear  = (stat.kind == KIND_CLEAR);
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        cmd.run = 1'b1;
        if (stat.search_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/sorted_table_intersection_count.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_table_intersection_count: two-table membership counter
// Appends to two sorted tables and counts probes found in both.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  kind, item_value
//   output   out_valid/out_stall  status, hit, match_count
//
// Load and clear items reach the result register once the output is free.
// A probe searches both tables side by side, one RAM read per cycle per table.
// Reset empties both tables and zeroes the count at once; no clearing pass.
// A new item is taken while a result waits; a stalled output holds the
// block only when the next result is ready to be written.
// ---------------------------------------------------------------------------
module sorted_table_intersection_count import stic_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic signed [VALUE_W-1:0] item_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic                      hit,
  output logic [MATCH_W-1:0]        match_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  stic_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind_in     (kind),
    .value_in    (item_value),
    .status      (status),
    .hit         (hit),
    .match_count (match_count)
  );

endmodule
